### sv/ncdc_pkg.sv
// shared types and constants for the nearest circle differential crossover block
package ncdc_pkg;

  localparam int MAX_SHAPES_DEF = 256;
  localparam int NUM_PARENTS    = 3;
  localparam int CFG_W          = 13;

  localparam logic [CFG_W-1:0] IMAGE_WIDTH_RST  = 13'd640;
  localparam logic [CFG_W-1:0] IMAGE_HEIGHT_RST = 13'd480;

  localparam logic CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic CFG_IMAGE_HEIGHT = 1'b1;

  // clip bounds
  localparam int COLOR_LO  = 0;
  localparam int COLOR_HI  = 255;
  localparam int ALPHA_LO  = 30;
  localparam int ALPHA_HI  = 60;
  localparam int RADIUS_LO = 2;
  localparam int RADIUS_HI = 10000;
  localparam int COORD_LO  = -16384;
  localparam int COORD_HI  = 16383;

  typedef enum logic [1:0] {
    OP_LOAD      = 2'd0,
    OP_LOAD_LAST = 2'd1,
    OP_CROSS     = 2'd2
  } opcode_t;

  typedef enum logic [2:0] {
    F_RED    = 3'd0,
    F_GREEN  = 3'd1,
    F_BLUE   = 3'd2,
    F_ALPHA  = 3'd3,
    F_RADIUS = 3'd4,
    F_CENTER = 3'd5
  } feature_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } color_t;

  typedef struct packed {
    logic [13:0]        radius;
    logic signed [14:0] cx;
    logic signed [14:0] cy;
  } geom_t;

endpackage

### sv/ncdc_ram.sv
// generic single-write, single-read synchronous ram with registered read data
module ncdc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/nearest_circle_differential_crossover.sv
// Nearest circle differential crossover. Three parent populations live in per-parent
// color and geometry rams, loaded one entry per request; a load-last request sets
// that parent's count. A crossover request scans all three parents in parallel, one
// stored circle per cycle through a read/difference/square/compare pipeline, then
// drains the pipeline and forms the sums before its done state loads the result
// register; a request that skips the search (apply clear, empty parent, unknown
// feature) goes straight to the done state. The scan runs over the largest parent
// count, its pace set by the single read port of each parent ram. One item is in
// work at a time; a finished result waits in the output register while the next
// request is accepted, and that next one holds in its done state until the output
// register frees up. The input is ready again as soon as a result is loaded. No
// clearing pass after reset: entries read before they are written are undefined.
// Configuration writes take effect at once.
module nearest_circle_differential_crossover #(
  parameter int MAX_SHAPES = ncdc_pkg::MAX_SHAPES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic                        cfg_index,
  input  logic [ncdc_pkg::CFG_W-1:0]  cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  opcode,
  input  logic [1:0]                  parent_select,
  input  logic [7:0]                  entry_index,
  input  logic [7:0]                  red,
  input  logic [7:0]                  green,
  input  logic [7:0]                  blue,
  input  logic [7:0]                  alpha,
  input  logic [13:0]                 radius,
  input  logic signed [14:0]          center_x,
  input  logic signed [14:0]          center_y,
  input  logic [2:0]                  feature_select,
  input  logic                        apply_crossover,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [7:0]                  out_red,
  output logic [7:0]                  out_green,
  output logic [7:0]                  out_blue,
  output logic [7:0]                  out_alpha,
  output logic [13:0]                 out_radius,
  output logic signed [14:0]          out_center_x,
  output logic signed [14:0]          out_center_y,
  output logic                        status
);
  import ncdc_pkg::*;

  localparam int IDX_W = (MAX_SHAPES > 1) ? $clog2(MAX_SHAPES) : 1;
  localparam int CNT_W = $clog2(MAX_SHAPES + 1);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SCAN  = 5'b00010,
    ST_DRAIN = 5'b00100,
    ST_SUM   = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  state_t state;

  logic [CFG_W-1:0] image_width;
  logic [CFG_W-1:0] image_height;
  logic [CNT_W-1:0] counts [NUM_PARENTS];
  logic [CNT_W-1:0] max_cnt;
  logic [IDX_W-1:0] scan_idx;

  logic in_acc;
  logic is_load;
  logic is_cross;
  logic any_empty;
  logic go_scan;
  logic scan_last;
  logic [CNT_W-1:0] max01;
  logic [CNT_W-1:0] max_all;

  // item held during the search
  logic [7:0]         it_red;
  logic [7:0]         it_green;
  logic [7:0]         it_blue;
  logic [7:0]         it_alpha;
  logic [13:0]        it_radius;
  logic signed [14:0] it_cx;
  logic signed [14:0] it_cy;
  logic [2:0]         it_feat;
  logic               it_xover;
  logic               it_status;

  // per-parent scan pipeline
  logic [NUM_PARENTS-1:0] iss_v;
  logic [NUM_PARENTS-1:0] s1_v;
  logic [NUM_PARENTS-1:0] s2_v;
  logic [30:0]            best_d     [NUM_PARENTS];
  geom_t                  best_geom  [NUM_PARENTS];
  color_t                 best_color [NUM_PARENTS];

  // sums of c1 + (c2 - c3)
  logic signed [9:0]  sum_col;
  logic signed [15:0] sum_rad;
  logic signed [16:0] sum_cx;
  logic signed [16:0] sum_cy;

  logic [7:0]         res_red;
  logic [7:0]         res_green;
  logic [7:0]         res_blue;
  logic [7:0]         res_alpha;
  logic [13:0]        res_radius;
  logic signed [14:0] res_cx;
  logic signed [14:0] res_cy;

  assign in_ready = (state == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign is_load  = in_acc && (opcode == OP_LOAD || opcode == OP_LOAD_LAST) &&
                    (parent_select < 2'(NUM_PARENTS)) && (int'(entry_index) < MAX_SHAPES);
  assign is_cross = in_acc && (opcode == OP_CROSS);

  assign any_empty = (counts[0] == '0) || (counts[1] == '0) || (counts[2] == '0);
  assign go_scan   = is_cross && apply_crossover && !any_empty && (feature_select <= F_CENTER);
  assign max01     = (counts[0] > counts[1]) ? counts[0] : counts[1];
  assign max_all   = (max01 > counts[2]) ? max01 : counts[2];
  assign scan_last = (CNT_W'(scan_idx) == max_cnt - CNT_W'(1));

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      out_valid    <= 1'b0;
      image_width  <= IMAGE_WIDTH_RST;
      image_height <= IMAGE_HEIGHT_RST;
      scan_idx     <= '0;
      max_cnt      <= '0;
      for (int p = 0; p < NUM_PARENTS; p++) begin
        counts[p] <= '0;
      end
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_IMAGE_WIDTH:  image_width  <= cfg_data;
          CFG_IMAGE_HEIGHT: image_height <= cfg_data;
          default: ;
        endcase
      end
      if (state == ST_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (is_load && opcode == OP_LOAD_LAST) begin
            counts[parent_select] <= CNT_W'(entry_index) + CNT_W'(1);
          end
          if (is_cross) begin
            if (go_scan) begin
              state    <= ST_SCAN;
              scan_idx <= '0;
              max_cnt  <= max_all;
            end else begin
              state <= ST_DONE;
            end
          end
        end
        ST_SCAN: begin
          scan_idx <= scan_idx + IDX_W'(1);
          if (scan_last) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!(|{iss_v, s1_v, s2_v})) begin
            state <= ST_SUM;
          end
        end
        ST_SUM: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid || out_ready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (is_cross) begin
      it_red    <= red;
      it_green  <= green;
      it_blue   <= blue;
      it_alpha  <= alpha;
      it_radius <= radius;
      it_cx     <= center_x;
      it_cy     <= center_y;
      it_feat   <= feature_select;
      it_xover  <= go_scan;
      it_status <= apply_crossover && any_empty;
    end
  end

  // one parent lane: rams, difference, square, running minimum
  for (genvar p = 0; p < NUM_PARENTS; p++) begin : g_parent
    logic               we;
    color_t             rd_color;
    geom_t              rd_geom;
    color_t             s1_color;
    geom_t              s1_geom;
    logic signed [15:0] s1_dx;
    logic signed [15:0] s1_dy;
    color_t             s2_color;
    geom_t              s2_geom;
    logic [29:0]        s2_sqx;
    logic [29:0]        s2_sqy;
    logic signed [31:0] prod_x;
    logic signed [31:0] prod_y;
    logic [30:0]        sq_dist;

    assign we = is_load && (parent_select == 2'(p));

    ncdc_ram #(.WIDTH($bits(color_t)), .DEPTH(MAX_SHAPES)) u_color (
      .clk   (clk),
      .we    (we),
      .waddr (IDX_W'(entry_index)),
      .wdata ({red, green, blue, alpha}),
      .raddr (scan_idx),
      .rdata (rd_color)
    );

    ncdc_ram #(.WIDTH($bits(geom_t)), .DEPTH(MAX_SHAPES)) u_geom (
      .clk   (clk),
      .we    (we),
      .waddr (IDX_W'(entry_index)),
      .wdata ({radius, center_x, center_y}),
      .raddr (scan_idx),
      .rdata (rd_geom)
    );

    assign prod_x  = s1_dx * s1_dx;
    assign prod_y  = s1_dy * s1_dy;
    assign sq_dist = {1'b0, s2_sqx} + {1'b0, s2_sqy};

    always_ff @(posedge clk) begin
      if (rst) begin
        iss_v[p] <= 1'b0;
        s1_v[p]  <= 1'b0;
        s2_v[p]  <= 1'b0;
      end else begin
        iss_v[p] <= (state == ST_SCAN) && (CNT_W'(scan_idx) < counts[p]);
        s1_v[p]  <= iss_v[p];
        s2_v[p]  <= s1_v[p];
      end
    end

    always_ff @(posedge clk) begin
      s1_color <= rd_color;
      s1_geom  <= rd_geom;
      s1_dx    <= 16'(rd_geom.cx) - 16'(it_cx);
      s1_dy    <= 16'(rd_geom.cy) - 16'(it_cy);
      s2_color <= s1_color;
      s2_geom  <= s1_geom;
      s2_sqx   <= prod_x[29:0];
      s2_sqy   <= prod_y[29:0];
      // strict less-than keeps the lowest index on a tie
      if (go_scan) begin
        best_d[p] <= '1;
      end else if (s2_v[p] && sq_dist < best_d[p]) begin
        best_d[p]     <= sq_dist;
        best_geom[p]  <= s2_geom;
        best_color[p] <= s2_color;
      end
    end
  end

  function automatic logic [7:0] pick_color(color_t c, logic [2:0] f);
    logic [7:0] v;
    case (f)
      F_RED:   v = c.red;
      F_GREEN: v = c.green;
      F_BLUE:  v = c.blue;
      default: v = c.alpha;
    endcase
    return v;
  endfunction

  always_ff @(posedge clk) begin
    if (state == ST_SUM) begin
      sum_col <= $signed({2'b00, pick_color(best_color[0], it_feat)}) +
                 ($signed({2'b00, pick_color(best_color[1], it_feat)}) -
                  $signed({2'b00, pick_color(best_color[2], it_feat)}));
      sum_rad <= $signed({2'b00, best_geom[0].radius}) +
                 ($signed({2'b00, best_geom[1].radius}) -
                  $signed({2'b00, best_geom[2].radius}));
      sum_cx  <= 17'(best_geom[0].cx) + (17'(best_geom[1].cx) - 17'(best_geom[2].cx));
      sum_cy  <= 17'(best_geom[0].cy) + (17'(best_geom[1].cy) - 17'(best_geom[2].cy));
    end
  end

  function automatic logic [7:0] clip_color(logic signed [9:0] v, logic is_alpha);
    logic signed [9:0] lo;
    logic signed [9:0] hi;
    logic [7:0]        r;
    lo = is_alpha ? 10'(ALPHA_LO) : 10'(COLOR_LO);
    hi = is_alpha ? 10'(ALPHA_HI) : 10'(COLOR_HI);
    if (v < lo) begin
      r = lo[7:0];
    end else if (v > hi) begin
      r = hi[7:0];
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

  function automatic logic signed [14:0] clip_coord(logic signed [16:0] v,
                                                    logic [13:0] rad,
                                                    logic [CFG_W-1:0] size);
    logic signed [16:0] lo;
    logic signed [16:0] hi;
    logic signed [16:0] c;
    logic signed [14:0] r;
    lo = -$signed({3'b000, rad});
    hi = $signed({4'b0000, size}) + $signed({3'b000, rad});
    if (v < lo) begin
      c = lo;
    end else if (v > hi) begin
      c = hi;
    end else begin
      c = v;
    end
    if (c < 17'(COORD_LO)) begin
      r = 15'(COORD_LO);
    end else if (c > 17'(COORD_HI)) begin
      r = 15'(COORD_HI);
    end else begin
      r = c[14:0];
    end
    return r;
  endfunction

  always_comb begin
    res_red    = it_red;
    res_green  = it_green;
    res_blue   = it_blue;
    res_alpha  = it_alpha;
    res_radius = it_radius;
    res_cx     = it_cx;
    res_cy     = it_cy;
    if (it_xover) begin
      case (it_feat)
        F_RED:   res_red   = clip_color(sum_col, 1'b0);
        F_GREEN: res_green = clip_color(sum_col, 1'b0);
        F_BLUE:  res_blue  = clip_color(sum_col, 1'b0);
        F_ALPHA: res_alpha = clip_color(sum_col, 1'b1);
        F_RADIUS: begin
          if (sum_rad < 16'(RADIUS_LO)) begin
            res_radius = 14'(RADIUS_LO);
          end else if (sum_rad > 16'(RADIUS_HI)) begin
            res_radius = 14'(RADIUS_HI);
          end else begin
            res_radius = sum_rad[13:0];
          end
        end
        F_CENTER: begin
          res_cx = clip_coord(sum_cx, it_radius, image_width);
          res_cy = clip_coord(sum_cy, it_radius, image_height);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && (!out_valid || out_ready)) begin
      out_red      <= res_red;
      out_green    <= res_green;
      out_blue     <= res_blue;
      out_alpha    <= res_alpha;
      out_radius   <= res_radius;
      out_center_x <= res_cx;
      out_center_y <= res_cy;
      status       <= it_status;
    end
  end

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> CNT_W'(scan_idx) < max_cnt)
    else $error("scan index beyond largest parent count");

  a_scan_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> !any_empty)
    else $error("search running with an empty parent");

  // only checked inside a search, where the running minimum has been seeded
  a_best_monotonic: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_SCAN || state == ST_DRAIN || state == ST_SUM) &&
     $past(state) != ST_IDLE) |->
      (best_d[0] <= $past(best_d[0]) && best_d[1] <= $past(best_d[1]) &&
       best_d[2] <= $past(best_d[2])))
    else $error("nearest distance grew during a search");

  a_drained: assert property (@(posedge clk) disable iff (rst)
    state == ST_SUM |-> !(|{iss_v, s1_v, s2_v}))
    else $error("sum started with scan pipeline still busy");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && (!out_valid || out_ready)) |=> (out_valid && state == ST_IDLE))
    else $error("finished request not moved to output register");

endmodule

### bench/tb.sv
// self-checking testbench for the nearest circle differential crossover block
`timescale 1ns / 1ps

module tb;
  import ncdc_pkg::*;

  localparam int ITEM_TARGET     = 1500;
  localparam int MAX_GAP         = 12;
  localparam int SETTLE_CYCLES   = MAX_SHAPES_DEF + 40;
  localparam int HOLD_OFF_CYCLES = 600;
  localparam int CYCLE_LIMIT     = 2_000_000;

  localparam logic [1:0] OP_RESERVED = 2'd3;
  localparam logic [1:0] PARENT_NONE = 2'd3;
  localparam logic [2:0] F_SPARE_LO  = 3'd6;
  localparam logic [2:0] F_SPARE_HI  = 3'd7;

  typedef struct packed {
    logic [1:0] opcode;
    logic [1:0] parent;
    logic [7:0] entry;
    color_t     color;
    geom_t      geom;
    logic [2:0] feature;
    logic       apply;
  } request_t;

  typedef struct packed {
    color_t color;
    geom_t  geom;
    logic   status;
  } circle_t;

  class crossover_tracker;
    color_t           colors[NUM_PARENTS][MAX_SHAPES_DEF];
    geom_t            geoms[NUM_PARENTS][MAX_SHAPES_DEF];
    int unsigned      counts[NUM_PARENTS];
    logic [CFG_W-1:0] img_width;
    logic [CFG_W-1:0] img_height;
    circle_t          expected_circles[$];
    int unsigned      errors, loads, crossovers, empty_hits, ignored, widest_scan;

    function new();
      img_width = IMAGE_WIDTH_RST;
      img_height = IMAGE_HEIGHT_RST;
      foreach (counts[p]) counts[p] = 0;
      errors = 0;
      loads = 0;
      crossovers = 0;
      empty_hits = 0;
      ignored = 0;
      widest_scan = 0;
    endfunction

    function void set_dims(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
      img_width = w;
      img_height = h;
    endfunction

    function int clamp(int v, int lo, int hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    function int unsigned closest(int p, int cx, int cy);
      longint best_d, dx, dy, d;
      int unsigned best, i;
      best = 0;
      best_d = 64'h7FFF_FFFF_FFFF_FFFF;
      for (i = 0; i < counts[p]; i++) begin
        dx = longint'($signed(geoms[p][i].cx)) - cx;
        dy = longint'($signed(geoms[p][i].cy)) - cy;
        d = dx * dx + dy * dy;
        // strict compare keeps the lowest index on a tie
        if (d < best_d) begin
          best_d = d;
          best = i;
        end
      end
      return best;
    endfunction

    function void note_request(request_t r);
      circle_t     res;
      int unsigned near[NUM_PARENTS];
      int          v, rad, sh, p;
      if (r.opcode == OP_LOAD || r.opcode == OP_LOAD_LAST) begin
        if (r.parent == PARENT_NONE) begin
          ignored++;
          return;
        end
        colors[r.parent][r.entry] = r.color;
        geoms[r.parent][r.entry] = r.geom;
        if (r.opcode == OP_LOAD_LAST) counts[r.parent] = r.entry + 1;
        loads++;
        return;
      end
      if (r.opcode != OP_CROSS) begin
        ignored++;
        return;
      end
      crossovers++;
      res.color = r.color;
      res.geom = r.geom;
      res.status = 1'b0;
      if (r.apply) begin
        if (counts[0] == 0 || counts[1] == 0 || counts[2] == 0) begin
          res.status = 1'b1;
          empty_hits++;
        end else if (r.feature <= F_CENTER) begin
          for (p = 0; p < NUM_PARENTS; p++) begin
            near[p] = closest(p, int'($signed(r.geom.cx)), int'($signed(r.geom.cy)));
            if (counts[p] > widest_scan) widest_scan = counts[p];
          end
          rad = int'(r.geom.radius);
          if (r.feature <= F_ALPHA) begin
            sh = 24 - 8 * int'(r.feature);
            v = int'(colors[0][near[0]][sh +: 8]) +
                (int'(colors[1][near[1]][sh +: 8]) - int'(colors[2][near[2]][sh +: 8]));
            if (r.feature == F_ALPHA) v = clamp(v, ALPHA_LO, ALPHA_HI);
            else v = clamp(v, COLOR_LO, COLOR_HI);
            res.color[sh +: 8] = 8'(v);
          end else if (r.feature == F_RADIUS) begin
            v = int'(geoms[0][near[0]].radius) +
                (int'(geoms[1][near[1]].radius) - int'(geoms[2][near[2]].radius));
            res.geom.radius = 14'(clamp(v, RADIUS_LO, RADIUS_HI));
          end else begin
            // center bounded by the item's own radius around the image, then saturated
            v = int'($signed(geoms[0][near[0]].cx)) +
                (int'($signed(geoms[1][near[1]].cx)) - int'($signed(geoms[2][near[2]].cx)));
            v = clamp(clamp(v, -rad, int'(img_width) + rad), COORD_LO, COORD_HI);
            res.geom.cx = 15'(v);
            v = int'($signed(geoms[0][near[0]].cy)) +
                (int'($signed(geoms[1][near[1]].cy)) - int'($signed(geoms[2][near[2]].cy)));
            v = clamp(clamp(v, -rad, int'(img_height) + rad), COORD_LO, COORD_HI);
            res.geom.cy = 15'(v);
          end
        end
      end
      expected_circles.push_back(res);
    endfunction

    function void compare(string name, int want, int got);
      if (want != got) begin
        $error("%s mismatch: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_circle(circle_t got);
      circle_t want;
      if (expected_circles.size() == 0) begin
        $error("result with no crossover request outstanding");
        errors++;
        return;
      end
      want = expected_circles.pop_front();
      compare("out_red", want.color.red, got.color.red);
      compare("out_green", want.color.green, got.color.green);
      compare("out_blue", want.color.blue, got.color.blue);
      compare("out_alpha", want.color.alpha, got.color.alpha);
      compare("out_radius", want.geom.radius, got.geom.radius);
      compare("out_center_x", int'($signed(want.geom.cx)), int'($signed(got.geom.cx)));
      compare("out_center_y", int'($signed(want.geom.cy)), int'($signed(got.geom.cy)));
      compare("status", want.status, got.status);
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_write = 1'b0;
  logic                cfg_index = CFG_IMAGE_WIDTH;
  logic [CFG_W-1:0]    cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [1:0]          opcode = OP_LOAD;
  logic [1:0]          parent_select = '0;
  logic [7:0]          entry_index = '0;
  logic [7:0]          red = '0;
  logic [7:0]          green = '0;
  logic [7:0]          blue = '0;
  logic [7:0]          alpha = '0;
  logic [13:0]         radius = '0;
  logic signed [14:0]  center_x = '0;
  logic signed [14:0]  center_y = '0;
  logic [2:0]          feature_select = F_RED;
  logic                apply_crossover = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [7:0]          out_red;
  logic [7:0]          out_green;
  logic [7:0]          out_blue;
  logic [7:0]          out_alpha;
  logic [13:0]         out_radius;
  logic signed [14:0]  out_center_x;
  logic signed [14:0]  out_center_y;
  logic                status;

  crossover_tracker tracker;
  bit               written[NUM_PARENTS][MAX_SHAPES_DEF];
  bit               sender_gapless, sink_gapless, hold_off_req;
  int unsigned      useful_sent, dim_writes, holds_requested;

  nearest_circle_differential_crossover DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned written_prefix(int p);
    int unsigned n;
    n = 0;
    while (n < MAX_SHAPES_DEF && written[p][n]) n++;
    return n;
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 5))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'($urandom_range(20, 70));
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic signed [14:0] pick_coord();
    case ($urandom_range(0, 4))
      0: return 15'(int'($urandom_range(0, 8)) - 4);  // clustered, so searches see ties
      1: return 15'($urandom);
      2: return $urandom_range(0, 1) ? 15'(COORD_HI) : 15'(COORD_LO);
      default: return 15'(int'($urandom_range(0, 1200)) - 300);
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_dim();
    case ($urandom_range(0, 4))
      0: return 13'd1;
      1: return 13'd4096;
      2: return 13'($urandom_range(1, 64));
      3: return IMAGE_WIDTH_RST;
      default: return 13'($urandom_range(1, 4096));
    endcase
  endfunction

  function automatic request_t random_circle();
    request_t r;
    r.opcode = OP_CROSS;
    r.parent = 2'($urandom);
    r.entry = 8'($urandom);
    r.color = {pick_byte(), pick_byte(), pick_byte(), pick_byte()};
    case ($urandom_range(0, 4))
      0: r.geom.radius = 14'd0;
      1: r.geom.radius = 14'(RADIUS_HI);
      2: r.geom.radius = 14'($urandom_range(0, 16));
      default: r.geom.radius = 14'($urandom_range(0, RADIUS_HI));
    endcase
    r.geom.cx = pick_coord();
    r.geom.cy = pick_coord();
    if ($urandom_range(0, 9) == 0) r.feature = $urandom_range(0, 1) ? F_SPARE_LO : F_SPARE_HI;
    else r.feature = 3'($urandom_range(F_RED, F_CENTER));
    r.apply = ($urandom_range(0, 7) != 0);
    return r;
  endfunction

  function automatic request_t make_load(logic [1:0] p, logic [7:0] e, bit want_last);
    request_t r;
    r = random_circle();
    r.opcode = OP_LOAD;
    r.parent = p;
    r.entry = e;
    if (p != PARENT_NONE) begin
      written[p][e] = 1'b1;
      // a count may only cover entries that hold data
      if (want_last && e < written_prefix(p)) r.opcode = OP_LOAD_LAST;
    end
    return r;
  endfunction

  function automatic request_t noise_request();
    request_t r;
    case ($urandom_range(0, 2))
      0: begin
        r = random_circle();
        r.opcode = OP_RESERVED;
      end
      1: r = make_load(PARENT_NONE, 8'($urandom), $urandom_range(0, 1));
      default: r = make_load(2'($urandom_range(0, NUM_PARENTS - 1)), 8'($urandom), 1'b1);
    endcase
    return r;
  endfunction

  task automatic send(request_t r);
    int gap;
    gap = sender_gapless ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    opcode <= r.opcode;
    parent_select <= r.parent;
    entry_index <= r.entry;
    red <= r.color.red;
    green <= r.color.green;
    blue <= r.color.blue;
    alpha <= r.color.alpha;
    radius <= r.geom.radius;
    center_x <= r.geom.cx;
    center_y <= r.geom.cy;
    feature_select <= r.feature;
    apply_crossover <= r.apply;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    tracker.note_request(r);
    if (r.opcode == OP_CROSS || (r.opcode != OP_RESERVED && r.parent != PARENT_NONE))
      useful_sent++;
    @(negedge clk);
  endtask

  task automatic settle_block();
    in_valid <= 1'b0;
    while (tracker.expected_circles.size() != 0) @(negedge clk);
    // loads leave no result behind, so give a full scan time on top
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_dims(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
    cfg_write <= 1'b1;
    cfg_index <= CFG_IMAGE_WIDTH;
    cfg_data <= w;
    @(negedge clk);
    cfg_index <= CFG_IMAGE_HEIGHT;
    cfg_data <= h;
    @(negedge clk);
    cfg_write <= 1'b0;
    tracker.set_dims(w, h);
    dim_writes++;
  endtask

  task automatic run_round(int round_no, int full_parent);
    int unsigned sizes[NUM_PARENTS];
    int          p, e, k, n_cross;
    settle_block();
    if (round_no < 2 || $urandom_range(0, 2) != 0) begin
      case (round_no)
        0: write_dims(13'd1, 13'd4096);
        1: write_dims(13'd4096, 13'd1);
        default: write_dims(pick_dim(), pick_dim());
      endcase
    end
    sender_gapless = ($urandom_range(0, 3) == 0);
    for (p = 0; p < NUM_PARENTS; p++) begin
      if (p == full_parent) sizes[p] = MAX_SHAPES_DEF;
      else if ($urandom_range(0, 4) == 0) sizes[p] = $urandom_range(9, 40);
      else sizes[p] = $urandom_range(1, 8);
    end
    for (p = 0; p < NUM_PARENTS; p++) begin
      for (e = 0; e < sizes[p]; e++) begin
        if ($urandom_range(0, 19) == 0) send(noise_request());
        send(make_load(2'(p), 8'(e), e == sizes[p] - 1));
      end
    end
    if (holds_requested < 2 && useful_sent > 400 + 700 * holds_requested) begin
      hold_off_req = 1'b1;
      holds_requested++;
    end
    n_cross = (full_parent >= 0) ? 10 : $urandom_range(6, 30);
    for (k = 0; k < n_cross; k++) begin
      // occasional rewrite inside the loaded range, may also shrink a count
      if ($urandom_range(0, 9) == 0) begin
        p = $urandom_range(0, NUM_PARENTS - 1);
        send(make_load(2'(p), 8'($urandom_range(0, sizes[p] - 1)), $urandom_range(0, 2) == 0));
      end
      send(random_circle());
    end
  endtask

  initial begin : stimulus
    request_t r;
    int       round_no, full_round;
    logic [2:0] f;
    tracker = new();
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // nothing loaded: apply set reports an empty parent, apply clear passes through
    r = random_circle();
    r.apply = 1'b1;
    r.feature = F_RED;
    r.geom = '{14'd0, 15'(COORD_LO), 15'(COORD_HI)};
    send(r);
    r = random_circle();
    r.apply = 1'b0;
    r.feature = F_CENTER;
    r.geom = '{14'(RADIUS_HI), 15'(COORD_HI), 15'(COORD_LO)};
    send(r);
    r = random_circle();
    r.opcode = OP_RESERVED;
    send(r);
    r = make_load(2'd0, 8'd0, 1'b1);
    r.color = '{8'd255, 8'd0, 8'd255, 8'd255};
    r.geom = '{14'(RADIUS_HI), 15'(COORD_HI), 15'(COORD_HI)};
    send(r);
    r = random_circle();
    r.apply = 1'b1;
    r.feature = F_RADIUS;
    send(r);
    r = make_load(2'd1, 8'd0, 1'b1);
    r.color = '{8'd255, 8'd255, 8'd0, 8'd0};
    r.geom = '{14'(RADIUS_HI), 15'(COORD_LO), 15'(COORD_LO)};
    send(r);
    r = make_load(2'd2, 8'd0, 1'b0);
    r.color = '{8'd0, 8'd0, 8'd255, 8'd0};
    r.geom = '{14'd0, 15'sd5, 15'sd5};
    send(r);
    // same center as entry 0, the tie has to go to entry 0
    r = make_load(2'd2, 8'd1, 1'b1);
    r.color = '{8'd9, 8'd200, 8'd1, 8'd77};
    r.geom = '{14'd3, 15'sd5, 15'sd5};
    send(r);
    send(make_load(PARENT_NONE, 8'd255, 1'b1));
    send(make_load(2'd0, 8'd255, 1'b0));
    for (f = F_RED; f < F_SPARE_HI; f++) begin
      r = random_circle();
      r.apply = 1'b1;
      r.feature = f;
      r.geom = '{14'($urandom_range(0, 1) ? 0 : RADIUS_HI), 15'sd5, 15'sd5};
      send(r);
    end
    r.feature = F_SPARE_HI;
    send(r);
    r.apply = 1'b0;
    r.feature = F_ALPHA;
    send(r);

    full_round = 3 + $urandom_range(0, 3);
    round_no = 0;
    while (useful_sent < ITEM_TARGET) begin
      run_round(round_no, (round_no == full_round) ? int'($urandom_range(0, 2)) : -1);
      round_no++;
    end
    settle_block();

    $display("run covered %0d loads, %0d crossovers (%0d on an empty parent), %0d ignored",
             tracker.loads, tracker.crossovers, tracker.empty_hits, tracker.ignored);
    $display("%0d rounds, %0d image size writes, largest parent searched: %0d entries",
             round_no, dim_writes, tracker.widest_scan);
    if (tracker.errors == 0) begin
      $display("[nearest_circle_differential_crossover] OK");
    end else begin
      $display("[nearest_circle_differential_crossover] ERROR");
    end
    $finish;
  end

  initial begin : result_sink
    circle_t     got;
    int          stall;
    int unsigned taken;
    taken = 0;
    while (rst) @(negedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall = HOLD_OFF_CYCLES;
      end else begin
        stall = sink_gapless ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      got.color = '{out_red, out_green, out_blue, out_alpha};
      got.geom = '{out_radius, out_center_x, out_center_y};
      got.status = status;
      tracker.check_circle(got);
      taken++;
      if (taken % 50 == 0) sink_gapless = ($urandom_range(0, 2) == 0);
      @(negedge clk);
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("[nearest_circle_differential_crossover] ERROR");
    $finish;
  end

endmodule
